/* hw/rtl/block_pixelate_palette_quantize_assert.svh */
// Assertion macros shared by the pixelation block RTL.
// Expects clk and rst_n in the scope where a macro is used.
`ifndef BLOCK_PIXELATE_PALETTE_QUANTIZE_ASSERT_SVH
`define BLOCK_PIXELATE_PALETTE_QUANTIZE_ASSERT_SVH

// General property, checked outside reset.
`define BPPQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same-cycle implication, checked outside reset.
`define BPPQ_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

/* hw/rtl/bppq_pkg.sv */
// Package for the pixelation / palette quantisation block.
// Shared types, defaults, register indices and arithmetic constants; no dependencies.
package bppq_pkg;

  localparam int DEF_PALETTE_DEPTH = 16;
  localparam int DEF_MAX_BLOCK     = 16;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 5;

  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PALETTE_COUNT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_QUANTIZE_EN   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_GRAY_EN       = 3'd3;

  localparam logic [4:0] RST_BLOCK_SIZE    = 5'd3;
  localparam logic [4:0] RST_PALETTE_COUNT = 5'd16;

  localparam logic [10:0] DIST_START = 11'd2000;

  // floor(y/3) = (y*683) >> 11, exact for y <= 765
  localparam logic [9:0] GRAY_MUL   = 10'd683;
  localparam int         GRAY_SHIFT = 11;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } rgb_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

endpackage

/* hw/rtl/bppq_div.sv */
// Three-lane restoring divider, one quotient bit per cycle, shared denominator.
// Depends on bppq_pkg and the assertion macro header.
`include "block_pixelate_palette_quantize_assert.svh"

module bppq_div import bppq_pkg::*; #(
  parameter int SUM_W  = 16,
  parameter int AREA_W = 9
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [2:0][SUM_W-1:0]  num,
  input  logic [AREA_W-1:0]      den,
  output logic [2:0][SUM_W-1:0]  quot,
  output div_sts_t               sts
);

  localparam int STEP_W = $clog2(SUM_W + 1);

  logic [2:0][SUM_W-1:0]  acc_r, acc_nxt;
  logic [2:0][AREA_W-1:0] rem_r, rem_nxt;
  logic [AREA_W-1:0]      den_r;
  logic [STEP_W-1:0]      step_r;
  logic                   busy_r, done_r;

  always_comb begin
    logic [AREA_W:0] trial;
    logic [AREA_W:0] diff;
    for (int l = 0; l < 3; l++) begin
      trial = {rem_r[l], acc_r[l][SUM_W-1]};
      diff  = trial - {1'b0, den_r};
      if (trial >= {1'b0, den_r}) begin
        rem_nxt[l] = diff[AREA_W-1:0];
        acc_nxt[l] = {acc_r[l][SUM_W-2:0], 1'b1};
      end else begin
        rem_nxt[l] = trial[AREA_W-1:0];
        acc_nxt[l] = {acc_r[l][SUM_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= STEP_W'(SUM_W);
      end else if (busy_r) begin
        step_r <= step_r - STEP_W'(1);
        if (step_r == STEP_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc_r <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (busy_r) begin
      acc_r <= acc_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign quot     = acc_r;
  assign sts.busy = busy_r;
  assign sts.done = done_r;

  `BPPQ_ASSERT_IMPL(a_start_when_idle, start, !busy_r, "divider started while busy")
  `BPPQ_ASSERT(a_done_after_busy, done_r |-> $past(busy_r), "divider done without a run")
  `BPPQ_ASSERT_IMPL(a_den_nonzero, busy_r, den_r != '0, "divider running on zero area")

endmodule

/* hw/rtl/bppq_pal_mem.sv */
// Palette store: one write port, one read port, registered read data.
// Depends on bppq_pkg for the colour type.
module bppq_pal_mem import bppq_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  rgb_t                     wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output rgb_t                     rd_data
);

  rgb_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* hw/rtl/block_pixelate_palette_quantize.sv */
// Block pixelation with optional nearest palette colour and grey output. Pixels and palette
// writes are taken only in idle. The last pixel of a block starts the divider (SUM_W = 16 by
// default); when quantising, palette_count entries (at least one, at most PALETTE_DEPTH) are then read.
// No new pixel is taken until the block's result has been loaded into the output register.
// Synchronous active-low reset clears sums, count, config, state and valid flags; palette and datapath undefined.
`include "block_pixelate_palette_quantize_assert.svh"

module block_pixelate_palette_quantize import bppq_pkg::*; #(
  parameter int PALETTE_DEPTH = DEF_PALETTE_DEPTH,
  parameter int MAX_BLOCK     = DEF_MAX_BLOCK
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_req_type,
  input  logic [3:0]            in_palette_slot,
  input  logic [7:0]            in_red,
  input  logic [7:0]            in_green,
  input  logic [7:0]            in_blue,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [7:0]            out_red,
  output logic [7:0]            out_green,
  output logic [7:0]            out_blue,
  output logic [3:0]            out_chosen_entry,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int EDGE_W = ($clog2(MAX_BLOCK + 1) > 5) ? $clog2(MAX_BLOCK + 1) : 5;
  localparam int AREA_W = $clog2(MAX_BLOCK * MAX_BLOCK + 1);
  localparam int SUM_W  = $clog2(MAX_BLOCK * MAX_BLOCK * 255 + 1);
  localparam int IDX_W  = $clog2(PALETTE_DEPTH);
  localparam int PN_W   = ($clog2(PALETTE_DEPTH + 1) > 5) ? $clog2(PALETTE_DEPTH + 1) : 5;

  typedef enum logic [1:0] {S_IDLE, S_DIV, S_SEARCH, S_OUT} state_t;

  state_t state_r, state_nxt;

  logic [4:0] block_size_r, palette_count_r;
  logic       quantize_en_r, gray_en_r;

  logic [SUM_W-1:0]  sum_red_r, sum_green_r, sum_blue_r;
  logic [SUM_W-1:0]  sum_red_nxt, sum_green_nxt, sum_blue_nxt;
  logic [AREA_W-1:0] cnt_r, cnt_nxt;

  logic [EDGE_W-1:0]   blk_edge;
  logic [2*EDGE_W-1:0] area_full;
  logic [AREA_W-1:0]   area;
  logic [PN_W-1:0]     pal_n;

  logic in_fire, pix_fire, blk_done, pal_wr;

  logic [2:0][SUM_W-1:0] div_num, div_quot;
  div_sts_t              div_sts;

  rgb_t            mean_r, col_r, rd_data;
  logic [PN_W-1:0] srch_idx_r;
  logic [IDX_W-1:0] rd_idx_r, chosen_r;
  logic            rd_pend_r, issue;
  logic [10:0]     best_r;
  logic [9:0]      pal_dist;

  logic [9:0]  ysum;
  logic [19:0] yprod;
  logic [7:0]  gray_y;

  logic       out_valid_r;
  rgb_t       out_col_r;
  logic [3:0] out_chosen_r;

  function automatic logic [7:0] absdiff(input logic [7:0] a, input logic [7:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

  function automatic logic [7:0] sat8(input logic [SUM_W-1:0] q);
    return (q > SUM_W'(255)) ? 8'd255 : q[7:0];
  endfunction

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_size_r    <= RST_BLOCK_SIZE;
      palette_count_r <= RST_PALETTE_COUNT;
      quantize_en_r   <= 1'b0;
      gray_en_r       <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_BLOCK_SIZE:    block_size_r    <= cfg_data;
        CFG_PALETTE_COUNT: palette_count_r <= cfg_data;
        CFG_QUANTIZE_EN:   quantize_en_r   <= cfg_data[0];
        CFG_GRAY_EN:       gray_en_r       <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // block geometry and search length
  always_comb begin
    blk_edge = EDGE_W'(block_size_r);
    if (block_size_r == 5'd0) begin
      blk_edge = EDGE_W'(1);
    end else if (blk_edge > EDGE_W'(MAX_BLOCK)) begin
      blk_edge = EDGE_W'(MAX_BLOCK);
    end
    pal_n = PN_W'(palette_count_r);
    if (palette_count_r == 5'd0) begin
      pal_n = PN_W'(1);
    end else if (pal_n > PN_W'(PALETTE_DEPTH)) begin
      pal_n = PN_W'(PALETTE_DEPTH);
    end
  end

  assign area_full = blk_edge * blk_edge;
  assign area      = area_full[AREA_W-1:0];

  // accumulation
  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign pix_fire = in_fire && !in_req_type;
  assign pal_wr   = in_fire && in_req_type && (32'(in_palette_slot) < PALETTE_DEPTH);

  assign sum_red_nxt   = sum_red_r + SUM_W'(in_red);
  assign sum_green_nxt = sum_green_r + SUM_W'(in_green);
  assign sum_blue_nxt  = sum_blue_r + SUM_W'(in_blue);
  assign cnt_nxt       = cnt_r + AREA_W'(1);
  assign blk_done      = pix_fire && (cnt_nxt >= area);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_red_r   <= '0;
      sum_green_r <= '0;
      sum_blue_r  <= '0;
      cnt_r       <= '0;
    end else if (pix_fire) begin
      if (blk_done) begin
        sum_red_r   <= '0;
        sum_green_r <= '0;
        sum_blue_r  <= '0;
        cnt_r       <= '0;
      end else begin
        sum_red_r   <= sum_red_nxt;
        sum_green_r <= sum_green_nxt;
        sum_blue_r  <= sum_blue_nxt;
        cnt_r       <= cnt_nxt;
      end
    end
  end

  assign div_num[0] = sum_red_nxt;
  assign div_num[1] = sum_green_nxt;
  assign div_num[2] = sum_blue_nxt;

  bppq_div #(
    .SUM_W  (SUM_W),
    .AREA_W (AREA_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (blk_done),
    .num   (div_num),
    .den   (area),
    .quot  (div_quot),
    .sts   (div_sts)
  );

  // palette search
  assign issue = (state_r == S_SEARCH) && (srch_idx_r < pal_n);

  bppq_pal_mem #(
    .DEPTH (PALETTE_DEPTH)
  ) u_pal (
    .clk     (clk),
    .wr_en   (pal_wr),
    .wr_addr (IDX_W'(in_palette_slot)),
    .wr_data ({in_red, in_green, in_blue}),
    .rd_en   (issue),
    .rd_addr (srch_idx_r[IDX_W-1:0]),
    .rd_data (rd_data)
  );

  assign pal_dist = 10'(absdiff(rd_data.r, mean_r.r)) + 10'(absdiff(rd_data.g, mean_r.g))
                  + 10'(absdiff(rd_data.b, mean_r.b));

  // grey conversion
  assign ysum   = 10'(col_r.r) + 10'(col_r.g) + 10'(col_r.b);
  assign yprod  = 20'(ysum) * 20'(GRAY_MUL);
  assign gray_y = 8'(yprod >> GRAY_SHIFT);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:   if (blk_done) state_nxt = S_DIV;
      S_DIV: begin
        if (div_sts.done) begin
          state_nxt = quantize_en_r ? S_SEARCH : S_OUT;
        end
      end
      S_SEARCH: if (!issue && !rd_pend_r) state_nxt = S_OUT;
      S_OUT:    if (!out_valid_r || out_ready) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      rd_pend_r    <= 1'b0;
      out_valid_r  <= 1'b0;
      srch_idx_r   <= '0;
    end else begin
      state_r   <= state_nxt;
      rd_pend_r <= issue;
      if (issue) begin
        srch_idx_r <= srch_idx_r + PN_W'(1);
      end else if (state_r != S_SEARCH) begin
        srch_idx_r <= '0;
      end
      if (state_r == S_OUT && (!out_valid_r || out_ready)) begin
        out_valid_r  <= 1'b1;
        out_col_r    <= gray_en_r ? {gray_y, gray_y, gray_y} : col_r;
        out_chosen_r <= 4'(chosen_r);
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r <= srch_idx_r[IDX_W-1:0];
    if (state_r == S_DIV && div_sts.done) begin
      mean_r   <= {sat8(div_quot[0]), sat8(div_quot[1]), sat8(div_quot[2])};
      col_r    <= {sat8(div_quot[0]), sat8(div_quot[1]), sat8(div_quot[2])};
      best_r   <= DIST_START;
      chosen_r <= '0;
    end else if (rd_pend_r && (11'(pal_dist) < best_r)) begin
      best_r   <= 11'(pal_dist);
      chosen_r <= rd_idx_r;
      col_r    <= rd_data;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_red          = out_col_r.r;
  assign out_green        = out_col_r.g;
  assign out_blue         = out_col_r.b;
  assign out_chosen_entry = out_chosen_r;

  `BPPQ_ASSERT_IMPL(a_div_done_in_div, div_sts.done, state_r == S_DIV, "divide ended outside S_DIV")
  `BPPQ_ASSERT_IMPL(a_read_in_search, rd_pend_r, state_r == S_SEARCH, "palette read outside search")
  `BPPQ_ASSERT_IMPL(a_no_accept_busy, div_sts.busy, !in_ready, "transaction taken while dividing")
  `BPPQ_ASSERT(a_out_from_final, $rose(out_valid_r) |-> $past(state_r == S_OUT), "result not from S_OUT")

endmodule
